// ===== rtl/u8u16_pkg.sv =====
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

   localparam int unsigned LIMIT_W       = 16;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd260;
   localparam int unsigned ACCUM_W       = 21;
   localparam int unsigned QUEUE_DEPTH   = 4;
   localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic KIND_UNIT = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_CONT = 2'd1;
   localparam logic [1:0] STATUS_NO_ROOM  = 2'd2;

   localparam logic [15:0] UNIT_REPLACE   = 16'h003F;
   localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
   localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
   localparam logic [ACCUM_W-1:0] PLANE1_BASE = 21'h10000;
   localparam logic [ACCUM_W-1:0] POINT_MAX   = 21'h10FFFF;

   localparam logic [1:0] REG_UNIT_LIMIT = 2'd0;

   typedef struct packed {
      logic        kind;
      logic [15:0] unit_value;
      logic [1:0]  status;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type res0;
      result_type res1;
   } push_type;

endpackage

// ===== rtl/u8u16_decode.sv =====
// Byte decoder: sequence state, code point assembly and UTF-16 unit generation.
module u8u16_decode (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [7:0]                       in_byte,
   input  logic [u8u16_pkg::LIMIT_W-1:0]    unit_limit,
   output u8u16_pkg::push_type              push
);

   logic [1:0]                          pending_ff, pending_in;
   logic [u8u16_pkg::ACCUM_W-1:0]       accum_ff, accum_in;
   logic [u8u16_pkg::LIMIT_W-1:0]       written_ff, written_in;
   logic                                discard_ff, discard_in;

   logic [u8u16_pkg::ACCUM_W-1:0]       accum_next;
   logic [u8u16_pkg::ACCUM_W-1:0]       cp;
   logic [u8u16_pkg::ACCUM_W-1:0]       cp_off;
   logic                                emit;
   logic                                is_cont;
   logic                                is_pair;
   logic                                no_room1;
   logic                                no_room2;
   logic                                over_limit;
   u8u16_pkg::push_type                 push_c;

   assign is_cont    = (in_byte[7:6] == 2'b10);
   assign accum_next = {accum_ff[u8u16_pkg::ACCUM_W-7:0], in_byte[5:0]};
   assign is_pair    = (cp >= u8u16_pkg::PLANE1_BASE) && (cp <= u8u16_pkg::POINT_MAX);
   assign cp_off     = cp - u8u16_pkg::PLANE1_BASE;
   assign no_room1   = ({1'b0, written_ff} + 17'd1) >= {1'b0, unit_limit};
   assign no_room2   = ({1'b0, written_ff} + 17'd2) >= {1'b0, unit_limit};
   assign over_limit = written_ff >= unit_limit;

   always_comb begin
      pending_in = pending_ff;
      accum_in   = accum_ff;
      written_in = written_ff;
      discard_in = discard_ff;
      emit       = 1'b0;
      cp         = '0;
      push_c     = '0;

      if (discard_ff) begin
         if (in_byte == 8'd0) begin
            pending_in = '0;
            accum_in   = '0;
            written_in = '0;
            discard_in = 1'b0;
         end
      end else if (pending_ff != 2'd0) begin
         if (!is_cont) begin
            push_c.count       = 2'd1;
            push_c.res0.kind   = u8u16_pkg::KIND_END;
            push_c.res0.status = u8u16_pkg::STATUS_BAD_CONT;
            pending_in = '0;
            accum_in   = '0;
            if (in_byte == 8'd0) begin
               written_in = '0;
               discard_in = 1'b0;
            end else begin
               discard_in = 1'b1;
            end
         end else begin
            accum_in   = accum_next;
            pending_in = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               emit     = 1'b1;
               cp       = accum_next;
               accum_in = '0;
            end
         end
      end else if (in_byte == 8'd0) begin
         push_c.count       = 2'd1;
         push_c.res0.kind   = u8u16_pkg::KIND_END;
         push_c.res0.status = over_limit ? u8u16_pkg::STATUS_NO_ROOM
                                         : u8u16_pkg::STATUS_OK;
         pending_in = '0;
         accum_in   = '0;
         written_in = '0;
         discard_in = 1'b0;
      end else if (!in_byte[7]) begin
         emit = 1'b1;
         cp   = {13'd0, in_byte};
      end else if (in_byte[7:5] == 3'b110) begin
         accum_in   = {16'd0, in_byte[4:0]};
         pending_in = 2'd1;
      end else if (in_byte[7:4] == 4'b1110) begin
         accum_in   = {17'd0, in_byte[3:0]};
         pending_in = 2'd2;
      end else if (in_byte[7:3] == 5'b11110) begin
         accum_in   = {18'd0, in_byte[2:0]};
         pending_in = 2'd3;
      end

      if (emit) begin
         if ((is_pair && no_room2) || (!is_pair && no_room1)) begin
            push_c.count       = 2'd1;
            push_c.res0.kind   = u8u16_pkg::KIND_END;
            push_c.res0.status = u8u16_pkg::STATUS_NO_ROOM;
            discard_in = 1'b1;
         end else if (is_pair) begin
            push_c.count           = 2'd2;
            push_c.res0.unit_value = u8u16_pkg::HIGH_SURR_BASE | {6'd0, cp_off[19:10]};
            push_c.res1.unit_value = u8u16_pkg::LOW_SURR_BASE | {6'd0, cp_off[9:0]};
            written_in = written_ff + 16'd2;
         end else begin
            push_c.count           = 2'd1;
            push_c.res0.unit_value = (cp <= 21'h00FFFF) ? cp[15:0]
                                                       : u8u16_pkg::UNIT_REPLACE;
            written_in = written_ff + 16'd1;
         end
      end

      if (push_c.count == 2'd1) begin
         push_c.res0.last = 1'b1;
      end
      if (push_c.count == 2'd2) begin
         push_c.res1.last = 1'b1;
      end
   end

   always_comb begin
      push = push_c;
      if (!accept) begin
         push.count = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         accum_ff   <= '0;
         written_ff <= '0;
         discard_ff <= 1'b0;
      end else if (accept) begin
         pending_ff <= pending_in;
         accum_ff   <= accum_in;
         written_ff <= written_in;
         discard_ff <= discard_in;
      end
   end

endmodule

// ===== rtl/u8u16_rspq.sv =====
// Result queue: takes up to two results a cycle, hands out one a cycle while pop is high.
module u8u16_rspq (
   input  logic                  clock,
   input  logic                  reset,
   input  u8u16_pkg::push_type   push,
   input  logic                  pop,
   output logic                  room,
   output logic                  head_valid,
   output u8u16_pkg::result_type head
);

   u8u16_pkg::result_type                 slot_ff [u8u16_pkg::QUEUE_DEPTH];
   logic [u8u16_pkg::QUEUE_PTR_W-1:0]     wr_ff, wr_in;
   logic [u8u16_pkg::QUEUE_PTR_W-1:0]     rd_ff, rd_in;
   logic [u8u16_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic [u8u16_pkg::QUEUE_PTR_W-1:0]     wr_next;
   logic                                  do_pop;

   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ff];
   assign room       = count_ff <= u8u16_pkg::QUEUE_CNT_W'(u8u16_pkg::QUEUE_DEPTH - 2);
   assign do_pop     = pop && head_valid;
   assign wr_next    = wr_ff + u8u16_pkg::QUEUE_PTR_W'(1);

   always_comb begin
      wr_in    = wr_ff + u8u16_pkg::QUEUE_PTR_W'(push.count);
      rd_in    = do_pop ? rd_ff + u8u16_pkg::QUEUE_PTR_W'(1) : rd_ff;
      count_in = count_ff + u8u16_pkg::QUEUE_CNT_W'(push.count)
                 - u8u16_pkg::QUEUE_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_next] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/utf8_to_utf16_transcoder_top.sv =====
// A request's results are registered in the result queue at the edge accepting it.
// One request per cycle while the result queue has room; a surrogate pair gives two
// results in one push, and the four-entry result queue absorbs the extra one.
// Reset (synchronous, active high) clears the decoder state and the queue
// and sets unit_limit to 260.
module utf8_to_utf16_transcoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] unit_value, [17:16] status, zero above
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [u8u16_pkg::LIMIT_W-1:0] unit_limit_ff;
   logic                          accept;
   logic                          room;
   logic                          csr_write;
   u8u16_pkg::push_type           push;
   u8u16_pkg::result_type         head;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr == u8u16_pkg::REG_UNIT_LIMIT);
   assign csr_prdata = (csr_paddr == u8u16_pkg::REG_UNIT_LIMIT)
                       ? {16'd0, unit_limit_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_limit_ff <= u8u16_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         unit_limit_ff <= csr_pwdata[15:0];
      end
   end

   assign req_tready = room;
   assign accept     = req_tvalid && room;

   u8u16_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_tdata),
      .unit_limit (unit_limit_ff),
      .push       (push)
   );

   u8u16_rspq u_rspq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_tready),
      .room       (room),
      .head_valid (rsp_tvalid),
      .head       (head)
   );

   assign rsp_tdata = {6'd0, head.status, head.unit_value};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

// ===== tb/utf16_result_checker.sv =====
// Result checker for the UTF-8 to UTF-16 transcoder: predicts each request and compares results.
module utf16_result_checker
   import u8u16_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [15:0] unit_value, [17:16] status, zero above
   input  logic        rsp_tuser,   // [0] kind
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          pending_count,
   output int          units_seen,
   output int          ends_seen,
   output int          aborts_seen
);

   localparam logic [1:0] LIMIT_ADDR = 2'(4 * REG_UNIT_LIMIT);
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;
   localparam logic [20:0] BMP_MAX   = 21'h00FFFF;

   logic [LIMIT_W-1:0] unit_limit;
   logic [1:0]         seq_left;
   logic [ACCUM_W-1:0] code_bits;
   logic [15:0]        units_out;
   logic               skipping;

   result_type expected_units[$];
   result_type step_out[2];
   int         step_n;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      units_seen     = 0;
      ends_seen      = 0;
      aborts_seen    = 0;
   end

   task automatic flag_mismatch(input string msg);
      if (mismatch_count < 10) $display("MISMATCH: %s", msg);
      mismatch_count++;
   endtask

   task automatic clear_string();
      seq_left  = 2'd0;
      code_bits = '0;
      units_out = '0;
      skipping  = 1'b0;
   endtask

   task automatic add_result(input logic kind, input logic [15:0] unit, input logic [1:0] status);
      step_out[step_n] = result_type'{kind: kind, unit_value: unit, status: status, last: 1'b0};
      step_n++;
   endtask

   task automatic encode_point(input logic [ACCUM_W-1:0] cp);
      logic [ACCUM_W-1:0] offs;
      int unsigned        used;
      used = units_out;
      if (cp >= PLANE1_BASE && cp <= POINT_MAX) begin
         if (used + 2 >= unit_limit) begin
            add_result(KIND_END, 16'h0000, STATUS_NO_ROOM);
            skipping = 1'b1;
         end else begin
            offs = cp - PLANE1_BASE;
            add_result(KIND_UNIT, HIGH_SURR_BASE + 16'(offs[19:10]), STATUS_OK);
            add_result(KIND_UNIT, LOW_SURR_BASE + 16'(offs[9:0]), STATUS_OK);
            units_out = units_out + 16'd2;
         end
      end else if (used + 1 >= unit_limit) begin
         add_result(KIND_END, 16'h0000, STATUS_NO_ROOM);
         skipping = 1'b1;
      end else begin
         add_result(KIND_UNIT, (cp <= BMP_MAX) ? cp[15:0] : UNIT_REPLACE, STATUS_OK);
         units_out = units_out + 16'd1;
      end
   endtask

   task automatic transcode_byte(input logic [7:0] b);
      result_type r;
      step_n = 0;
      if (skipping) begin
         if (b == 8'h00) clear_string();
      end else if (seq_left != 2'd0) begin
         if ((b & CONT_MASK) != CONT_TAG) begin
            add_result(KIND_END, 16'h0000, STATUS_BAD_CONT);
            if (b == 8'h00) begin
               clear_string();
            end else begin
               seq_left  = 2'd0;
               code_bits = '0;
               skipping  = 1'b1;
            end
         end else begin
            code_bits = {code_bits[ACCUM_W-7:0], b[5:0]};
            seq_left  = seq_left - 2'd1;
            if (seq_left == 2'd0) begin
               encode_point(code_bits);
               code_bits = '0;
            end
         end
      end else if (b == 8'h00) begin
         add_result(KIND_END, 16'h0000, (units_out >= unit_limit) ? STATUS_NO_ROOM : STATUS_OK);
         clear_string();
      end else if (b < CONT_TAG) begin
         encode_point(ACCUM_W'(b));
      end else if ((b & LEAD2_MASK) == CONT_MASK) begin
         code_bits = ACCUM_W'(b[4:0]);
         seq_left  = 2'd1;
      end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
         code_bits = ACCUM_W'(b[3:0]);
         seq_left  = 2'd2;
      end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
         code_bits = ACCUM_W'(b[2:0]);
         seq_left  = 2'd3;
      end
      for (int i = 0; i < step_n; i++) begin
         r = step_out[i];
         r.last = (i == step_n - 1);
         expected_units.push_back(r);
      end
   endtask

   task automatic check_result();
      result_type got;
      result_type want;
      got = result_type'{kind: rsp_tuser, unit_value: rsp_tdata[15:0],
                         status: rsp_tdata[17:16], last: rsp_tlast};
      if (got.kind == KIND_UNIT) begin
         units_seen++;
      end else begin
         ends_seen++;
         if (got.status != STATUS_OK) aborts_seen++;
      end
      if (expected_units.size() == 0) begin
         flag_mismatch($sformatf("unexpected result kind %0d unit %h status %0d last %0d",
                                 got.kind, got.unit_value, got.status, got.last));
      end else begin
         want = expected_units.pop_front();
         if (got !== want || rsp_tdata[23:18] !== 6'd0)
            flag_mismatch($sformatf({"expected kind %0d unit %h status %0d last %0d, ",
                                     "got kind %0d unit %h status %0d last %0d pad %h"},
                                    want.kind, want.unit_value, want.status, want.last,
                                    got.kind, got.unit_value, got.status, got.last,
                                    rsp_tdata[23:18]));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         unit_limit = LIMIT_RESET;
         clear_string();
         expected_units.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_psel && csr_penable && csr_pready && csr_paddr == LIMIT_ADDR) begin
            if (csr_pwrite) begin
               unit_limit = csr_pwdata[LIMIT_W-1:0];
            end else if (csr_prdata !== {16'h0000, unit_limit}) begin
               flag_mismatch($sformatf("unit_limit read expected %h got %h",
                                       {16'h0000, unit_limit}, csr_prdata));
            end
         end
         if (req_tvalid && req_tready) transcode_byte(req_tdata);
      end
      pending_count = expected_units.size();
   end

endmodule

// ===== tb/testbench.sv =====
// Top-level testbench for the UTF-8 to UTF-16 transcoder: stimulus, flow control and verdict.
module testbench;
   import u8u16_pkg::*;

   localparam logic [1:0] LIMIT_ADDR  = 2'(4 * REG_UNIT_LIMIT);
   localparam int         IDLE_LIMIT  = 3000;
   localparam int         HOLD_CYCLES = 400;
   localparam int         PHASE_BYTES = 215;
   localparam int         PHASES      = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = 2'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int pending_count;
   int units_seen;
   int ends_seen;
   int aborts_seen;

   int         bytes_sent = 0;
   int         limits_set = 0;
   int         idle_cycles = 0;
   bit         send_calm = 1'b0;
   logic [7:0] byte_plan[$];

   utf8_to_utf16_transcoder_top dut (.*);

   utf16_result_checker u16_check (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("utf8_to_utf16_transcoder_top test failed");
            $finish;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   task automatic flush_plan();
      foreach (byte_plan[i]) send_byte(byte_plan[i]);
      byte_plan.delete();
   endtask

   task automatic csr_access(input logic wr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= LIMIT_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_limit(input logic [15:0] value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_access(1'b1, {16'h0000, value});
      @(negedge clock);
      csr_access(1'b0, 32'd0);
      limits_set++;
   endtask

   task automatic plan_cont();
      byte_plan.push_back(8'h80 | 8'($urandom_range(0, 63)));
   endtask

   task automatic plan_lead(output int conts);
      conts = $urandom_range(1, 3);
      case (conts)
         1: byte_plan.push_back(8'hC0 | 8'($urandom_range(0, 31)));
         2: byte_plan.push_back(8'hE0 | 8'($urandom_range(0, 15)));
         default: byte_plan.push_back(8'hF0 | 8'($urandom_range(0, 7)));
      endcase
   endtask

   task automatic plan_string();
      int points;
      int conts;
      points = $urandom_range(0, 12);
      for (int p = 0; p < points; p++) begin
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 4))
               0: byte_plan.push_back(8'($urandom_range(0, 255)));
               1: byte_plan.push_back(8'($urandom_range(8'hF8, 8'hFF)));
               2: byte_plan.push_back(8'($urandom_range(8'h80, 8'hBF)));
               3: begin
                  plan_lead(conts);
                  if ($urandom_range(0, 1) == 0)
                     byte_plan.push_back(8'($urandom_range(1, 127)));
                  else
                     byte_plan.push_back(8'($urandom_range(8'hC0, 8'hFF)));
               end
               default: begin
                  plan_lead(conts);
                  byte_plan.push_back(8'h00);
               end
            endcase
         end else if ($urandom_range(0, 3) == 0) begin
            byte_plan.push_back(8'($urandom_range(1, 127)));
         end else begin
            plan_lead(conts);
            repeat (conts) plan_cont();
         end
      end
      if ($urandom_range(0, 9) != 0) byte_plan.push_back(8'h00);
   endtask

   initial begin : sink
      int stall;
      int taken;
      bit calm;
      taken = 0;
      calm  = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) calm = !calm;
         stall = calm ? 0 : $urandom_range(0, 14);
         if (taken == 150) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
         @(negedge clock);
      end
   end

   initial begin : source
      logic [15:0] limit;
      int          start;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // widest forms, supplementary range edges, skipped bytes, overlong and surrogate forms
      byte_plan = '{8'h7F, 8'hC2, 8'h80, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
                    8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hFF, 8'h80,
                    8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'h00};
      flush_plan();
      // bad continuation then discard; zero inside a sequence
      byte_plan = '{8'hC3, 8'h41, 8'h42, 8'h00, 8'hE2, 8'h00, 8'h41};
      flush_plan();
      // lower the limit mid-string so the terminator reports no room
      set_limit(16'd1);
      byte_plan = '{8'h00, 8'h41, 8'h00};
      flush_plan();
      set_limit(16'd3);
      byte_plan = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'h41, 8'h00};
      flush_plan();
      set_limit(16'd65535);

      for (int ph = 0; ph < PHASES; ph++) begin
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) begin
            plan_string();
            flush_plan();
         end
         case ($urandom_range(0, 5))
            0: limit = 16'd1;
            1: limit = 16'($urandom_range(2, 4));
            2: limit = 16'($urandom_range(5, 40));
            3: limit = LIMIT_RESET;
            4: limit = 16'd65535;
            default: limit = 16'($urandom_range(1, 65535));
         endcase
         if (ph == PHASES - 2) limit = 16'd1;
         set_limit(limit);
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("%0d bytes sent under %0d unit limit settings, with a long result hold-off",
               bytes_sent, limits_set);
      $display("%0d code units and %0d string ends checked, %0d ends aborted",
               units_seen, ends_seen, aborts_seen);
      if (mismatch_count == 0) begin
         $display("utf8_to_utf16_transcoder_top test passed");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("utf8_to_utf16_transcoder_top test failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/u8u16_pkg.sv
rtl/u8u16_decode.sv
rtl/u8u16_rspq.sv
rtl/utf8_to_utf16_transcoder_top.sv
tb/utf16_result_checker.sv
tb/testbench.sv
